// ----- hdl/lgi_pkg.sv -----
// Shared types and constants for the Lagrange interpolation block.
// Holds the float unit's operation codes and its request and response words.
// No dependencies.
package lgi_pkg;

    typedef enum logic [1:0] {
        FOP_ADD = 2'd0,
        FOP_SUB = 2'd1,
        FOP_MUL = 2'd2,
        FOP_DIV = 2'd3
    } fp_op_t;

    typedef struct packed {
        logic        start;
        fp_op_t      op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } fpu_rsp_t;

    localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
    localparam logic [31:0] FP_POS_ZERO = 32'h0000_0000;

endpackage

// ----- hdl/lgi_fpu.sv -----
// Multi-cycle IEEE single-precision add, subtract, multiply and divide unit.
// Rounds to nearest even with subnormal support; divide is one quotient bit a cycle.
// Depends on lgi_pkg.
module lgi_fpu
    import lgi_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  fpu_req_t req,
    output fpu_rsp_t rsp
);

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_PREP  = 6'b000010,
        F_CORE  = 6'b000100,
        F_DIV   = 6'b001000,
        F_NORM  = 6'b010000,
        F_ROUND = 6'b100000
    } fstate_t;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int k = 0; k < 24; k++) begin
            if (v[k]) n = 5'(23 - k);
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc50(input logic [49:0] v);
        logic [5:0] n;
        n = 6'd50;
        for (int k = 0; k < 50; k++) begin
            if (v[k]) n = 6'(49 - k);
        end
        return n;
    endfunction

    fstate_t            state_reg;
    fp_op_t             op_reg;
    logic [31:0]        a_reg, b_reg;
    logic               sa_reg, sb_reg;
    logic signed [10:0] ea_reg, eb_reg;
    logic [23:0]        ma_reg, mb_reg;
    logic               spec_reg;
    logic [31:0]        spec_val_reg;
    logic               sign_reg;
    logic signed [10:0] exp_reg;
    logic [49:0]        sig_reg;
    logic               sticky_reg;
    logic               zero_reg;
    logic [26:0]        m27_reg;
    logic [25:0]        rem_reg;
    logic [26:0]        quo_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        res_reg;
    logic               done_reg;

    // Operand decode.
    logic [31:0]        b_eff;
    logic [7:0]         a_exp, b_exp;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0]        ma_raw, mb_raw, ma_n, mb_n;
    logic [4:0]         lz_a, lz_b;
    logic signed [10:0] ea_n, eb_n;
    logic               spec;
    logic [31:0]        spec_val;
    logic               s_xor;

    always_comb begin
        b_eff  = (op_reg == FOP_SUB) ? {~b_reg[31], b_reg[30:0]} : b_reg;
        a_exp  = a_reg[30:23];
        b_exp  = b_eff[30:23];
        a_nan  = (a_exp == 8'hFF) && (a_reg[22:0] != 23'd0);
        b_nan  = (b_exp == 8'hFF) && (b_eff[22:0] != 23'd0);
        a_inf  = (a_exp == 8'hFF) && (a_reg[22:0] == 23'd0);
        b_inf  = (b_exp == 8'hFF) && (b_eff[22:0] == 23'd0);
        a_zero = (a_reg[30:0] == 31'd0);
        b_zero = (b_eff[30:0] == 31'd0);
        ma_raw = {a_exp != 8'd0, a_reg[22:0]};
        mb_raw = {b_exp != 8'd0, b_eff[22:0]};
        lz_a   = lzc24(ma_raw);
        lz_b   = lzc24(mb_raw);
        ma_n   = ma_raw << lz_a;
        mb_n   = mb_raw << lz_b;
        ea_n   = $signed({3'b000, (a_exp == 8'd0) ? 8'd1 : a_exp}) - $signed({6'd0, lz_a});
        eb_n   = $signed({3'b000, (b_exp == 8'd0) ? 8'd1 : b_exp}) - $signed({6'd0, lz_b});
        s_xor  = a_reg[31] ^ b_eff[31];

        spec     = 1'b0;
        spec_val = FP_QNAN;
        unique case (op_reg)
            FOP_ADD, FOP_SUB: begin
                if (a_nan || b_nan || (a_inf && b_inf && (a_reg[31] != b_eff[31]))) begin
                    spec = 1'b1;
                end else if (a_inf) begin
                    spec = 1'b1; spec_val = a_reg;
                end else if (b_inf) begin
                    spec = 1'b1; spec_val = b_eff;
                end else if (a_zero && b_zero) begin
                    spec = 1'b1; spec_val = {a_reg[31] & b_eff[31], 31'd0};
                end else if (a_zero) begin
                    spec = 1'b1; spec_val = b_eff;
                end else if (b_zero) begin
                    spec = 1'b1; spec_val = a_reg;
                end
            end
            FOP_MUL: begin
                if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                    spec = 1'b1;
                end else if (a_inf || b_inf) begin
                    spec = 1'b1; spec_val = {s_xor, 8'hFF, 23'd0};
                end else if (a_zero || b_zero) begin
                    spec = 1'b1; spec_val = {s_xor, 31'd0};
                end
            end
            FOP_DIV: begin
                if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                    spec = 1'b1;
                end else if (a_inf || b_zero) begin
                    spec = 1'b1; spec_val = {s_xor, 8'hFF, 23'd0};
                end else if (a_zero || b_inf) begin
                    spec = 1'b1; spec_val = {s_xor, 31'd0};
                end
            end
            default: spec = 1'b1;
        endcase
    end

    // Alignment adder and multiplier.
    logic               a_big;
    logic signed [10:0] e_big, e_small, diff;
    logic [23:0]        m_big, m_small;
    logic               s_big;
    logic [49:0]        big_full, small_full, small_sh, small_j, sum;
    logic               lost;
    logic [47:0]        prod;

    always_comb begin
        a_big   = (ea_reg > eb_reg) || ((ea_reg == eb_reg) && (ma_reg >= mb_reg));
        e_big   = a_big ? ea_reg : eb_reg;
        e_small = a_big ? eb_reg : ea_reg;
        m_big   = a_big ? ma_reg : mb_reg;
        m_small = a_big ? mb_reg : ma_reg;
        s_big   = a_big ? sa_reg : sb_reg;
        diff    = e_big - e_small;
        big_full   = {1'b0, m_big, 25'd0};
        small_full = {1'b0, m_small, 25'd0};
        if (diff >= 11'sd50) begin
            small_sh = 50'd0;
            lost     = 1'b1;
        end else begin
            small_sh = small_full >> diff[5:0];
            lost     = ((small_sh << diff[5:0]) != small_full);
        end
        small_j = small_sh | {49'd0, lost};
        sum     = (sa_reg == sb_reg) ? (big_full + small_j) : (big_full - small_j);
        prod    = ma_reg * mb_reg;
    end

    // Divider step.
    logic        ge;
    logic [25:0] rem_sub;
    logic [26:0] quo_n;

    always_comb begin
        ge      = rem_reg >= {2'b00, mb_reg};
        rem_sub = ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;
        quo_n   = {quo_reg[25:0], ge};
    end

    // Normalizer.
    logic [5:0]         lz;
    logic [49:0]        sig_n;
    logic signed [10:0] exp_n;

    always_comb begin
        lz    = lzc50(sig_reg);
        sig_n = sig_reg << lz;
        exp_n = exp_reg + 11'sd1 - $signed({5'd0, lz});
    end

    // Rounder and packer.
    logic               subn;
    logic signed [10:0] sh;
    logic [26:0]        ms_sh, ms;
    logic               lost_r;
    logic [7:0]         efield;
    logic               inc;
    logic [30:0]        packed_v;
    logic [31:0]        res;

    always_comb begin
        subn   = exp_reg < 11'sd1;
        sh     = 11'sd1 - exp_reg;
        ms_sh  = 27'd0;
        lost_r = 1'b0;
        if (subn) begin
            if (sh >= 11'sd27) begin
                ms = {26'd0, |m27_reg};
            end else begin
                ms_sh  = m27_reg >> sh[4:0];
                lost_r = ((ms_sh << sh[4:0]) != m27_reg);
                ms     = ms_sh | {26'd0, lost_r};
            end
            efield = 8'd0;
        end else begin
            ms     = m27_reg;
            efield = exp_reg[7:0];
        end
        inc      = ms[2] & (ms[1] | ms[0] | ms[3]);
        packed_v = {efield, ms[25:3]} + {30'd0, inc};
        if (spec_reg) begin
            res = spec_val_reg;
        end else if (zero_reg) begin
            res = {sign_reg, 31'd0};
        end else if (!subn && (exp_reg >= 11'sd255)) begin
            res = {sign_reg, 8'hFF, 23'd0};
        end else begin
            res = {sign_reg, packed_v};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == F_ROUND);
            unique case (state_reg)
                F_IDLE: begin
                    if (req.start) begin
                        a_reg     <= req.a;
                        b_reg     <= req.b;
                        op_reg    <= req.op;
                        state_reg <= F_PREP;
                    end
                end
                F_PREP: begin
                    sa_reg       <= a_reg[31];
                    sb_reg       <= b_eff[31];
                    ea_reg       <= ea_n;
                    eb_reg       <= eb_n;
                    ma_reg       <= ma_n;
                    mb_reg       <= mb_n;
                    spec_reg     <= spec;
                    spec_val_reg <= spec_val;
                    rem_reg      <= {2'b00, ma_n};
                    quo_reg      <= 27'd0;
                    cnt_reg      <= 5'd0;
                    if (spec) begin
                        state_reg <= F_ROUND;
                    end else if (op_reg == FOP_DIV) begin
                        state_reg <= F_DIV;
                    end else begin
                        state_reg <= F_CORE;
                    end
                end
                F_CORE: begin
                    sticky_reg <= 1'b0;
                    if (op_reg == FOP_MUL) begin
                        sig_reg  <= {prod, 2'b00};
                        exp_reg  <= ea_reg + eb_reg - 11'sd127;
                        sign_reg <= sa_reg ^ sb_reg;
                        zero_reg <= 1'b0;
                    end else begin
                        sig_reg  <= sum;
                        exp_reg  <= e_big;
                        sign_reg <= (sum == 50'd0) ? 1'b0 : s_big;
                        zero_reg <= (sum == 50'd0);
                    end
                    state_reg <= F_NORM;
                end
                F_DIV: begin
                    if (cnt_reg == 5'd26) begin
                        sig_reg    <= {1'b0, quo_n, 22'd0};
                        exp_reg    <= ea_reg - eb_reg + 11'sd127;
                        sign_reg   <= sa_reg ^ sb_reg;
                        sticky_reg <= (rem_sub != 26'd0);
                        zero_reg   <= 1'b0;
                        state_reg  <= F_NORM;
                    end else begin
                        rem_reg <= {rem_sub[24:0], 1'b0};
                        quo_reg <= quo_n;
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                F_NORM: begin
                    m27_reg   <= {sig_n[49:24], (|sig_n[23:0]) | sticky_reg};
                    exp_reg   <= exp_n;
                    state_reg <= F_ROUND;
                end
                F_ROUND: begin
                    res_reg   <= res;
                    state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// ----- hdl/lagrange_interpolation.sv -----
// Lagrange polynomial interpolation over single-precision sample points.
// Top level: point store, evaluation sequencer and stream ports; uses lgi_pkg and lgi_fpu.
//
// Each input word carries one sample point (x, y) and is stored; after a word without
// tlast the block stays ready for the next word. The word with tlast also carries the
// query abscissa and starts the evaluation y = sum_i yi * prod_{j!=i}(q - xj) /
// prod_{j!=i}(xi - xj), computed in IEEE single arithmetic with round-to-nearest-even on
// one shared float unit. For n stored points the unit runs 4*n*(n-1) subtract and
// multiply operations, n divides and 2*n more multiply and add operations, with a store
// read for each point and each pair. The block takes no new word while a set is being
// evaluated. The result word echoes the query, gives the interpolated value (any NaN as
// 0x7FC00000) and flags repeated abscissas and points dropped because the store of
// MAX_POINTS entries was full. The point store empties after every result.
module lagrange_interpolation
    import lgi_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x [31:0], point_y [63:32], query_x [95:64]
    input  logic        s_tlast,   // last_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_x [31:0], result_y [63:32]
    output logic [1:0]  m_tuser    // duplicate_node [0], points_dropped [1]
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_RD_I  = 8'b00000010,
        ST_LAT_I = 8'b00000100,
        ST_RD_J  = 8'b00001000,
        ST_LAT_J = 8'b00010000,
        ST_OP    = 8'b00100000,
        ST_WAIT  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    typedef enum logic [2:0] {
        STP_NSUB = 3'd0,
        STP_NMUL = 3'd1,
        STP_DSUB = 3'd2,
        STP_DMUL = 3'd3,
        STP_WDIV = 3'd4,
        STP_WMUL = 3'd5,
        STP_YADD = 3'd6
    } step_t;

    // Float equality: +0 equals -0, NaN equals nothing.
    function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
        logic a_nan, b_nan;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        return !a_nan && !b_nan && ((a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)));
    endfunction

    logic [31:0] x_mem [MAX_POINTS];
    logic [31:0] y_mem [MAX_POINTS];
    logic [31:0] x_rd_reg, y_rd_reg;
    logic [AW-1:0] rd_addr;

    state_t      state_reg;
    step_t       step_reg;
    logic [CW-1:0] count_reg, i_reg, j_reg;
    logic        ovf_reg, dup_reg;
    logic [31:0] q_reg, xi_reg, yi_reg, xj_reg;
    logic [31:0] num_reg, den_reg, tmp_reg, acc_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    fpu_req_t    fpu_req;
    fpu_rsp_t    fpu_rsp;
    logic        s_accept;
    logic        store_ok;
    logic [31:0] y_final;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign store_ok = (count_reg < CW'(MAX_POINTS));
    assign rd_addr  = (state_reg == ST_RD_I) ? i_reg[AW-1:0] : j_reg[AW-1:0];

    // The point store: one write port on input words, one registered read port.
    always_ff @(posedge aclk) begin
        if (s_accept && store_ok) begin
            x_mem[count_reg[AW-1:0]] <= s_tdata[31:0];
            y_mem[count_reg[AW-1:0]] <= s_tdata[63:32];
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    // Operand selection for the float unit, one operation per step.
    always_comb begin
        fpu_req.start = (state_reg == ST_OP);
        fpu_req.op    = FOP_SUB;
        fpu_req.a     = q_reg;
        fpu_req.b     = xj_reg;
        unique case (step_reg)
            STP_NSUB: begin fpu_req.op = FOP_SUB; fpu_req.a = q_reg;   fpu_req.b = xj_reg;  end
            STP_NMUL: begin fpu_req.op = FOP_MUL; fpu_req.a = num_reg; fpu_req.b = tmp_reg; end
            STP_DSUB: begin fpu_req.op = FOP_SUB; fpu_req.a = xi_reg;  fpu_req.b = xj_reg;  end
            STP_DMUL: begin fpu_req.op = FOP_MUL; fpu_req.a = den_reg; fpu_req.b = tmp_reg; end
            STP_WDIV: begin fpu_req.op = FOP_DIV; fpu_req.a = num_reg; fpu_req.b = den_reg; end
            STP_WMUL: begin fpu_req.op = FOP_MUL; fpu_req.a = tmp_reg; fpu_req.b = yi_reg;  end
            STP_YADD: begin fpu_req.op = FOP_ADD; fpu_req.a = acc_reg; fpu_req.b = tmp_reg; end
            default:  begin fpu_req.op = FOP_ADD; fpu_req.a = acc_reg; fpu_req.b = tmp_reg; end
        endcase
    end

    lgi_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .rsp     (fpu_rsp)
    );

    assign y_final = ((acc_reg[30:23] == 8'hFF) && (acc_reg[22:0] != 23'd0)) ? FP_QNAN : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= STP_NSUB;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // In ST_OUT the output register is reloaded below instead.
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (store_ok) begin
                            count_reg <= count_reg + CW'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            q_reg     <= s_tdata[95:64];
                            acc_reg   <= FP_POS_ZERO;
                            dup_reg   <= 1'b0;
                            i_reg     <= '0;
                            state_reg <= ST_RD_I;
                        end
                    end
                end
                ST_RD_I: begin
                    state_reg <= ST_LAT_I;
                end
                ST_LAT_I: begin
                    xi_reg    <= x_rd_reg;
                    yi_reg    <= y_rd_reg;
                    num_reg   <= FP_ONE;
                    den_reg   <= FP_ONE;
                    j_reg     <= '0;
                    state_reg <= ST_RD_J;
                end
                ST_RD_J: begin
                    if (j_reg == count_reg) begin
                        step_reg  <= STP_WDIV;
                        state_reg <= ST_OP;
                    end else if (j_reg == i_reg) begin
                        j_reg <= j_reg + CW'(1);
                    end else begin
                        state_reg <= ST_LAT_J;
                    end
                end
                ST_LAT_J: begin
                    xj_reg    <= x_rd_reg;
                    dup_reg   <= dup_reg | feq(xi_reg, x_rd_reg);
                    step_reg  <= STP_NSUB;
                    state_reg <= ST_OP;
                end
                ST_OP: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (fpu_rsp.done) begin
                        unique case (step_reg)
                            STP_NSUB: begin
                                tmp_reg   <= fpu_rsp.result;
                                step_reg  <= STP_NMUL;
                                state_reg <= ST_OP;
                            end
                            STP_NMUL: begin
                                num_reg   <= fpu_rsp.result;
                                step_reg  <= STP_DSUB;
                                state_reg <= ST_OP;
                            end
                            STP_DSUB: begin
                                tmp_reg   <= fpu_rsp.result;
                                step_reg  <= STP_DMUL;
                                state_reg <= ST_OP;
                            end
                            STP_DMUL: begin
                                den_reg   <= fpu_rsp.result;
                                j_reg     <= j_reg + CW'(1);
                                state_reg <= ST_RD_J;
                            end
                            STP_WDIV: begin
                                tmp_reg   <= fpu_rsp.result;
                                step_reg  <= STP_WMUL;
                                state_reg <= ST_OP;
                            end
                            STP_WMUL: begin
                                tmp_reg   <= fpu_rsp.result;
                                step_reg  <= STP_YADD;
                                state_reg <= ST_OP;
                            end
                            STP_YADD: begin
                                acc_reg <= fpu_rsp.result;
                                i_reg   <= i_reg + CW'(1);
                                if (i_reg + CW'(1) == count_reg) begin
                                    state_reg <= ST_OUT;
                                end else begin
                                    state_reg <= ST_RD_I;
                                end
                            end
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_OUT: begin
                    // Wait for the output register to be free, then release the set.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {y_final, q_reg};
                        m_tuser_reg  <= {ovf_reg, dup_reg};
                        count_reg    <= '0;
                        ovf_reg      <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
